// ===== src/assert_macros.svh =====
// Assertion macros for the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high
`define SHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sha256 check failed");

// Concurrent check that also runs through reset
`define SHA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sha256 reset check failed");

`endif

// ===== src/sha256_pkg.sv =====
// Types and constants of the SHA-256 stream hasher
package sha256_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
  localparam int FILL_W      = $clog2(BLOCK_BYTES);
  localparam int ROUNDS      = 64;
  localparam int RND_W       = $clog2(ROUNDS);
  localparam int HASH_WORDS  = 8;
  localparam int WSEL_W      = $clog2(HASH_WORDS);

  localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(BLOCK_BYTES - 1);
  localparam logic [FILL_W-1:0] LEN_START  = FILL_W'(56);
  localparam logic [RND_W-1:0]  ROUND_LAST = RND_W'(ROUNDS - 1);
  localparam logic [WSEL_W-1:0] WORD_LAST  = WSEL_W'(HASH_WORDS - 1);
  localparam logic [7:0]        PAD_MARK_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_VECTOR [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } result_t;

  typedef struct packed {
    logic start;
    logic restart;
  } core_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WAIT,
    S_PAD,
    S_OUT
  } st_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_stage_t;

endpackage

// ===== src/sha256_core.sv =====
// Compression unit: one SHA-256 round per cycle, message schedule window, hash words
module sha256_core import sha256_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  core_ctl_t             ctl,
  input  logic [BLOCK_BITS-1:0] blk,
  input  logic [WSEL_W-1:0]     wsel,
  output logic                  done,
  output logic [31:0]           digest
);

  logic [31:0]      hash [HASH_WORDS];
  logic [31:0]      v    [HASH_WORDS];
  logic [31:0]      w    [16];
  logic [RND_W-1:0] rnd;
  logic             busy;
  logic             adding;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_next;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_next = w[0] + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[9]
             + (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      adding <= 1'b0;
      rnd    <= '0;
      for (int i = 0; i < HASH_WORDS; i++) hash[i] <= INIT_VECTOR[i];
    end else begin
      adding <= 1'b0;
      if (ctl.restart) begin
        for (int i = 0; i < HASH_WORDS; i++) hash[i] <= INIT_VECTOR[i];
      end else if (ctl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == ROUND_LAST) begin
          busy   <= 1'b0;
          adding <= 1'b1;
        end
      end else if (adding) begin
        for (int i = 0; i < HASH_WORDS; i++) hash[i] <= hash[i] + v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < HASH_WORDS; i++) v[i] <= hash[i];
      for (int i = 0; i < 16; i++) w[i] <= blk[BLOCK_BITS-1-32*i -: 32];
    end else if (busy) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_next;
    end
  end

  assign done   = adding;
  assign digest = hash[wsel];

endmodule

// ===== src/sha256_stream_hasher_top.sv =====
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer, digest output
// An idle hasher takes an item without a full block in the cycle it is offered. A byte that
// completes a 64-byte block holds the input off for one load, 64 rounds through the shared
// round unit and one fold into the hash words. End of message: padding and one or two
// compressions precede digest word 0, the rest follow one per cycle while result_ready is
// high. Synchronous rst loads the initial vector.
module sha256_stream_hasher_top import sha256_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  st_t                   state, state_next;
  pad_stage_t            stage, stage_next;
  logic                  padding, padding_next;
  logic [63:0]           bit_count, bit_count_next;
  logic [WSEL_W-1:0]     wsel, wsel_next;
  logic [FILL_W-1:0]     fill;
  logic [BLOCK_BITS-1:0] blk;
  logic                  ins;
  logic [7:0]            ins_byte;
  logic                  load_out;
  core_ctl_t             ctl;
  logic                  done;
  logic [31:0]           digest;

  sha256_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .blk    (blk),
    .wsel   (wsel),
    .done   (done),
    .digest (digest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    stage_next     = stage;
    padding_next   = padding;
    bit_count_next = bit_count;
    wsel_next      = wsel;
    ins            = 1'b0;
    ins_byte       = item.data_byte;
    load_out       = 1'b0;
    ctl            = '0;
    item_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item.byte_present) begin
            ins            = 1'b1;
            bit_count_next = bit_count + 64'd8;
          end
          if (item.end_of_message) begin
            padding_next = 1'b1;
            stage_next   = PAD_MARK;
          end
          if (item.byte_present && fill == FILL_LAST) begin
            state_next = S_LOAD;
          end else if (item.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_LOAD: begin
        ctl.start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (done) begin
          if (!padding) begin
            state_next = S_IDLE;
          end else if (stage == PAD_LEN) begin
            wsel_next  = '0;
            state_next = S_OUT;
          end else begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        case (stage)
          PAD_MARK: begin
            ins        = 1'b1;
            ins_byte   = PAD_MARK_BYTE;
            stage_next = PAD_ZERO;
            if (fill == FILL_LAST) state_next = S_LOAD;
          end
          PAD_ZERO: begin
            if (fill == LEN_START) begin
              stage_next = PAD_LEN;
            end else begin
              ins      = 1'b1;
              ins_byte = 8'h00;
              if (fill == FILL_LAST) state_next = S_LOAD;
            end
          end
          PAD_LEN: begin
            ins            = 1'b1;
            ins_byte       = bit_count[63:56];
            bit_count_next = {bit_count[55:0], 8'h00};
            if (fill == FILL_LAST) state_next = S_LOAD;
          end
          default: stage_next = PAD_MARK;
        endcase
      end
      S_OUT: begin
        if (!result_valid || result_ready) begin
          load_out  = 1'b1;
          wsel_next = wsel + 1'b1;
          if (wsel == WORD_LAST) begin
            ctl.restart    = 1'b1;
            padding_next   = 1'b0;
            bit_count_next = '0;
            state_next     = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= PAD_MARK;
      padding      <= 1'b0;
      bit_count    <= '0;
      wsel         <= '0;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      stage     <= stage_next;
      padding   <= padding_next;
      bit_count <= bit_count_next;
      wsel      <= wsel_next;
      if (ins) fill <= fill + 1'b1;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins) blk <= {blk[BLOCK_BITS-9:0], ins_byte};
    if (load_out) begin
      result.digest_word <= digest;
      result.last_word   <= (wsel == WORD_LAST);
    end
  end

endmodule

// ===== src/sha256_chk.sv =====
// Port checker for the SHA-256 stream hasher, bound to the top level
`include "assert_macros.svh"

module sha256_chk import sha256_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  `SHA_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result))
  `SHA_ASSERT(a_end_blocks_input, item_valid && item_ready && item.end_of_message |=> !item_ready)
  `SHA_ASSERT(a_words_back_to_back, result_valid && result_ready && !result.last_word |=> result_valid)
  `SHA_ASSERT(a_last_word_once, result_valid && result_ready && result.last_word |=> !result_valid)
  `SHA_ASSERT_RST(a_reset_idle, rst |=> !result_valid && item_ready)

endmodule

bind sha256_stream_hasher_top sha256_chk u_chk (.*);
